FILE: design/bus_breakpoint_tracer_unit_assert.svh
// Assertion macros used by the checker in bbt_checker.sv.
`ifndef BUS_BREAKPOINT_TRACER_UNIT_ASSERT_SVH
`define BUS_BREAKPOINT_TRACER_UNIT_ASSERT_SVH

// Checked at every edge outside reset.
`define BBT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication to the next edge, also checked while reset is high.
`define BBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/bbt_pkg.sv
package bbt_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  localparam logic [CfgIdxW-1:0] RegBreakAddress     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMatchAny         = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCheckDirection   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegExpectedDirection = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCheckData        = 3'd4;
  localparam logic [CfgIdxW-1:0] RegExpectedData     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegQuietMode        = 3'd6;

  localparam logic KindTrace = 1'b0;
  localparam logic KindBreak = 1'b1;

  localparam logic [7:0] TraceFlagBase = 8'h80;

  // One classified bus cycle, waiting for the back end.
  typedef struct packed {
    logic        trace;
    logic        brk;
    logic [7:0]  flags;
    logic [7:0]  data;
    logic [15:0] addr;
  } bbt_entry_t;

endpackage

FILE: design/bbt_bus_if.sv
interface bbt_bus_if;
  logic        valid;
  logic        ready;
  logic [15:0] bus_address;
  logic [7:0]  bus_data;
  logic        read_line;
  logic        program_valid;
  logic        data_valid;

  modport source (output valid, bus_address, bus_data, read_line, program_valid,
                  data_valid, input ready);
  modport sink (input valid, bus_address, bus_data, read_line, program_valid,
                data_valid, output ready);
endinterface

FILE: design/bbt_rec_if.sv
interface bbt_rec_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [7:0]  flag_byte;
  logic [7:0]  seen_data;
  logic [15:0] seen_address;
  logic        is_last;

  modport source (output valid, record_kind, flag_byte, seen_data, seen_address,
                  is_last, input ready);
  modport sink (input valid, record_kind, flag_byte, seen_data, seen_address,
                is_last, output ready);
endinterface

FILE: design/bbt_cfg_if.sv
interface bbt_cfg_if;
  import bbt_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/bus_breakpoint_tracer_unit.sv
// Bus breakpoint tracer.
// bus: one watched processor bus cycle per transfer (address, data, read line,
//   program and data strobes). A cycle with neither strobe set is dropped.
// rec: trace and break records. A traced cycle gives a trace record; a break
//   gives a break record with zero payload, after the trace record of the same
//   cycle. is_last marks the final record of one bus cycle.
// cfg: register writes (index 0..6); any write to a listed register clears
//   the halt. cfg.ready is always high; indexes past the list are ignored.
// Throughput: one bus cycle per clock while the queue has room; a cycle giving
//   two records sends them on the record port one after the other.
//   Classification feeds a 4-entry queue, the output stage drains it into a
//   record register.
// After a break, bus transfers are still taken but dropped until a write to a listed register.
// When rec stalls, the queue fills and bus.ready drops after four entries.
// Reset clears all registers to zero, the halt, the queue and the record stage.
module bus_breakpoint_tracer_unit (
  input  logic    clk,
  input  logic    rst,
  bbt_bus_if.sink bus,
  bbt_cfg_if.sink cfg,
  bbt_rec_if.source rec
);
  import bbt_pkg::*;

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  bbt_entry_t q_in;
  bbt_entry_t q_out;

  bbt_front u_front (
    .clk    (clk),
    .rst    (rst),
    .bus    (bus),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  bbt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  bbt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .rec     (rec)
  );
endmodule

FILE: design/bbt_fifo.sv
module bbt_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bbt_pkg::bbt_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output bbt_pkg::bbt_entry_t pop_data,
  output logic               empty
);
  import bbt_pkg::*;

  bbt_entry_t       slots [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == QCntW'(QDepth));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end
endmodule

FILE: design/bbt_front.sv
module bbt_front (
  input  logic                clk,
  input  logic                rst,
  bbt_bus_if.sink             bus,
  bbt_cfg_if.sink             cfg,
  input  logic                q_full,
  output logic                q_push,
  output bbt_pkg::bbt_entry_t q_data
);
  import bbt_pkg::*;

  logic [15:0] break_address;
  logic        match_any;
  logic        check_direction;
  logic        expected_direction;
  logic        check_data;
  logic [7:0]  expected_data;
  logic        quiet_mode;
  logic        halted;

  logic        accept;
  logic        live;
  logic        fire;
  logic        cfg_hit;
  logic        data_ok;
  logic        dir_ok;

  assign bus.ready = !q_full;
  assign cfg.ready = 1'b1;

  assign accept  = bus.valid && bus.ready;
  assign live    = accept && !halted && (bus.program_valid || bus.data_valid);
  assign data_ok = !check_data || (bus.bus_data == expected_data);
  assign dir_ok  = !check_direction || (bus.read_line == expected_direction);
  assign fire    = (bus.bus_address == break_address) && (match_any || (data_ok && dir_ok));

  assign q_push       = live && (!quiet_mode || fire);
  assign q_data.trace = !quiet_mode;
  assign q_data.brk   = fire;
  assign q_data.flags = TraceFlagBase | {5'b0, bus.program_valid, bus.data_valid,
                                         bus.read_line};
  assign q_data.data  = bus.bus_data;
  assign q_data.addr  = bus.bus_address;

  always_comb begin
    case (cfg.index)
      RegBreakAddress, RegMatchAny, RegCheckDirection, RegExpectedDirection,
      RegCheckData, RegExpectedData, RegQuietMode: cfg_hit = cfg.valid;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      break_address      <= '0;
      match_any          <= 1'b0;
      check_direction    <= 1'b0;
      expected_direction <= 1'b0;
      check_data         <= 1'b0;
      expected_data      <= '0;
      quiet_mode         <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        RegBreakAddress:      break_address      <= cfg.data;
        RegMatchAny:          match_any          <= cfg.data[0];
        RegCheckDirection:    check_direction    <= cfg.data[0];
        RegExpectedDirection: expected_direction <= cfg.data[0];
        RegCheckData:         check_data         <= cfg.data[0];
        RegExpectedData:      expected_data      <= cfg.data[7:0];
        RegQuietMode:         quiet_mode         <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // halt is set as the break is classified, so the very next item is dropped; cfg_hit wins
  always_ff @(posedge clk) begin
    if (rst) begin
      halted <= 1'b0;
    end else if (cfg_hit) begin
      halted <= 1'b0;
    end else if (live && fire) begin
      halted <= 1'b1;
    end
  end
endmodule

FILE: design/bbt_back.sv
module bbt_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  bbt_pkg::bbt_entry_t q_data,
  output logic                q_pop,
  bbt_rec_if.source           rec
);
  import bbt_pkg::*;

  logic        out_valid;
  logic        kind;
  logic [7:0]  flags;
  logic [7:0]  data;
  logic [15:0] addr;
  logic        last;
  logic        pend_brk;
  logic        can_load;

  assign can_load = !out_valid || rec.ready;
  assign q_pop    = can_load && !pend_brk && !q_empty;

  assign rec.valid        = out_valid;
  assign rec.record_kind  = kind;
  assign rec.flag_byte    = flags;
  assign rec.seen_data    = data;
  assign rec.seen_address = addr;
  assign rec.is_last      = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_brk  <= 1'b0;
    end else if (can_load) begin
      if (pend_brk) begin
        out_valid <= 1'b1;
        pend_brk  <= 1'b0;
      end else if (!q_empty) begin
        out_valid <= 1'b1;
        pend_brk  <= q_data.trace && q_data.brk;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // a queued entry always carries a trace record, a break, or both
  always_ff @(posedge clk) begin
    if (can_load) begin
      if (pend_brk || (!q_empty && !q_data.trace)) begin
        kind  <= KindBreak;
        flags <= '0;
        data  <= '0;
        addr  <= '0;
        last  <= 1'b1;
      end else if (!q_empty) begin
        kind  <= KindTrace;
        flags <= q_data.flags;
        data  <= q_data.data;
        addr  <= q_data.addr;
        last  <= !q_data.brk;
      end
    end
  end
endmodule

FILE: design/bbt_checker.sv
`include "bus_breakpoint_tracer_unit_assert.svh"

module bbt_checker (
  input logic        clk,
  input logic        rst,
  input logic        rec_valid,
  input logic        rec_ready,
  input logic        record_kind,
  input logic [7:0]  flag_byte,
  input logic [7:0]  seen_data,
  input logic [15:0] seen_address,
  input logic        is_last
);

  `BBT_ASSERT(a_rec_hold, (rec_valid && !rec_ready) |=> (rec_valid && $stable(record_kind) && $stable(flag_byte) && $stable(seen_data) && $stable(seen_address) && $stable(is_last)), "record changed while stalled")

  `BBT_ASSERT(a_break_shape, (rec_valid && record_kind) |-> (flag_byte == 8'h00 && seen_data == 8'h00 && seen_address == 16'h0000 && is_last), "malformed break record")

  `BBT_ASSERT(a_trace_flags, (rec_valid && !record_kind) |-> (flag_byte[7:3] == 5'b10000 && flag_byte[2:1] != 2'b00), "bad trace flag byte")

  `BBT_ASSERT_NEXT(a_reset_idle, rst, !rec_valid, "record valid after reset")

endmodule

bind bus_breakpoint_tracer_unit bbt_checker u_bbt_checker (
  .clk          (clk),
  .rst          (rst),
  .rec_valid    (rec.valid),
  .rec_ready    (rec.ready),
  .record_kind  (rec.record_kind),
  .flag_byte    (rec.flag_byte),
  .seen_data    (rec.seen_data),
  .seen_address (rec.seen_address),
  .is_last      (rec.is_last)
);

FILE: tb/trace_record_checker.sv
module trace_record_checker
  import bbt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  bbt_bus_if   bus,
  bbt_cfg_if   cfg,
  bbt_rec_if   rec,
  output int   errors,
  output int   due_count,
  output logic halted
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        kind;
    logic [7:0]  flags;
    logic [7:0]  data;
    logic [15:0] addr;
    logic        last;
  } trace_rec_t;

  trace_rec_t records_due[$];

  logic [15:0] brk_addr;
  logic        match_any;
  logic        chk_dir;
  logic        want_read;
  logic        chk_data;
  logic [7:0]  want_data;
  logic        quiet;

  initial begin
    errors    = 0;
    due_count = 0;
    halted    = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: record mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  task automatic apply_reg_write(input logic [CfgIdxW-1:0] idx,
                                 input logic [CfgDataW-1:0] val);
    case (idx)
      RegBreakAddress:      brk_addr  = val[15:0];
      RegMatchAny:          match_any = val[0];
      RegCheckDirection:    chk_dir   = val[0];
      RegExpectedDirection: want_read = val[0];
      RegCheckData:         chk_data  = val[0];
      RegExpectedData:      want_data = val[7:0];
      RegQuietMode:         quiet     = val[0];
      default:              return;  // unlisted index: no effect, halt stays
    endcase
    halted = 1'b0;
  endtask

  task automatic predict_bus_cycle(input logic [15:0] addr, input logic [7:0] data,
                                   input logic rw, input logic pv, input logic dv);
    logic       fire;
    trace_rec_t r;
    if (halted || !(pv || dv)) begin
      return;
    end
    fire = (addr == brk_addr) &&
           (match_any || (!(chk_data && data != want_data) &&
                          !(chk_dir && rw != want_read)));
    if (!quiet) begin
      r = '{KindTrace, TraceFlagBase | {5'd0, pv, dv, rw}, data, addr, !fire};
      records_due.push_back(r);
    end
    if (fire) begin
      r = '{KindBreak, 8'd0, 8'd0, 16'd0, 1'b1};
      records_due.push_back(r);
      halted = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    trace_rec_t want;
    if (rst) begin
      records_due.delete();
      brk_addr  = '0;
      match_any = 1'b0;
      chk_dir   = 1'b0;
      want_read = 1'b0;
      chk_data  = 1'b0;
      want_data = '0;
      quiet     = 1'b0;
      halted    = 1'b0;
    end else begin
      if (rec.valid && rec.ready) begin
        if (records_due.size() == 0) begin
          report_mismatch($sformatf("unexpected record kind %b flags %h data %h addr %h",
                                    rec.record_kind, rec.flag_byte, rec.seen_data,
                                    rec.seen_address));
        end else begin
          want = records_due.pop_front();
          check_field("record_kind", 16'(rec.record_kind), 16'(want.kind));
          check_field("flag_byte", 16'(rec.flag_byte), 16'(want.flags));
          check_field("seen_data", 16'(rec.seen_data), 16'(want.data));
          check_field("seen_address", rec.seen_address, want.addr);
          check_field("is_last", 16'(rec.is_last), 16'(want.last));
        end
      end
      if (bus.valid && bus.ready) begin
        predict_bus_cycle(bus.bus_address, bus.bus_data, bus.read_line,
                          bus.program_valid, bus.data_valid);
      end
      if (cfg.valid && cfg.ready) begin
        apply_reg_write(cfg.index, cfg.data);
      end
    end
    due_count = records_due.size();
  end

endmodule

FILE: tb/tb.sv
module tb;
  import bbt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TargetItems = 650;
  localparam int PhaseItems  = 60;
  localparam int CycleLimit  = 200000;
  localparam logic [CfgIdxW-1:0] RegUnlisted = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   due_count;
  logic halted;
  int   cycle_count = 0;
  int   counted = 0;
  int   phase_n;
  int   idle_pct = 33;
  int   stall_pct = 73;

  // stimulus-side copy of what was written, to aim addresses and data at hits
  logic [15:0] cur_brk_addr = '0;
  logic [7:0]  cur_want_data = '0;

  bbt_bus_if bus ();
  bbt_cfg_if cfg ();
  bbt_rec_if rec ();

  bus_breakpoint_tracer_unit dut (
    .clk (clk),
    .rst (rst),
    .bus (bus),
    .cfg (cfg),
    .rec (rec)
  );

  trace_record_checker chk (
    .clk       (clk),
    .rst       (rst),
    .bus       (bus),
    .cfg       (cfg),
    .rec       (rec),
    .errors    (fail_count),
    .due_count (due_count),
    .halted    (halted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    rec.ready = ($urandom_range(99) >= stall_pct);
  end

  task automatic update_idling();
    if (counted < TargetItems / 3) begin
      idle_pct  = 33;
      stall_pct = 73;
    end else if (counted < 2 * TargetItems / 3) begin
      idle_pct  = 73;
      stall_pct = 33;
    end else begin
      idle_pct  = 0;
      stall_pct = 0;
    end
  endtask

  task automatic wait_idle();
    bus.valid = 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg.index = idx;
    cfg.data  = val;
    cfg.valid = 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid = 1'b0;
    if (idx == RegBreakAddress) cur_brk_addr = val;
    if (idx == RegExpectedData) cur_want_data = val[7:0];
  endtask

  // Leaves valid high on return; the caller lowers it or drives the next transfer.
  task automatic send_cycle(input logic [15:0] addr, input logic [7:0] data,
                            input logic rw, input logic pv, input logic dv);
    counted++;
    update_idling();
    while ($urandom_range(99) < idle_pct) begin
      bus.valid = 1'b0;
      @(negedge clk);
    end
    bus.bus_address   = addr;
    bus.bus_data      = data;
    bus.read_line     = rw;
    bus.program_valid = pv;
    bus.data_valid    = dv;
    bus.valid         = 1'b1;
    @(posedge clk);
    while (!bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_cycle();
    logic [15:0] addr;
    logic [7:0]  data;
    logic [1:0]  strobes;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 12) addr = cur_brk_addr;
    else if (pick < 15) addr = 16'h0000;
    else if (pick < 18) addr = 16'hFFFF;
    else addr = 16'($urandom_range(16'hFFFF));
    data    = ($urandom_range(3) == 0) ? cur_want_data : 8'($urandom_range(255));
    strobes = 2'($urandom_range(3));
    send_cycle(addr, data, 1'($urandom_range(1)), strobes[1], strobes[0]);
    phase_n++;
    // hold off now and then until the block has caught up
    if (counted == TargetItems / 2 || $urandom_range(99) == 0) wait_idle();
  endtask

  task automatic new_settings();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) write_reg(RegBreakAddress, 16'h0000);
    else if (pick == 1) write_reg(RegBreakAddress, 16'hFFFF);
    else write_reg(RegBreakAddress, 16'($urandom_range(16'hFFFF)));
    if ($urandom_range(1)) write_reg(RegMatchAny, 16'($urandom_range(16'hFFFF)));
    if ($urandom_range(1)) write_reg(RegCheckDirection, 16'($urandom_range(16'hFFFF)));
    if ($urandom_range(1)) write_reg(RegExpectedDirection, 16'($urandom_range(16'hFFFF)));
    if ($urandom_range(1)) write_reg(RegCheckData, 16'($urandom_range(16'hFFFF)));
    if ($urandom_range(1)) write_reg(RegExpectedData, 16'($urandom_range(16'hFFFF)));
    if ($urandom_range(3) == 0) write_reg(RegQuietMode, 16'($urandom_range(16'hFFFF)));
  endtask

  initial begin
    bus.valid         = 1'b0;
    bus.bus_address   = '0;
    bus.bus_data      = '0;
    bus.read_line     = 1'b0;
    bus.program_valid = 1'b0;
    bus.data_valid    = 1'b0;
    cfg.valid         = 1'b0;
    cfg.index         = '0;
    cfg.data          = '0;
    rec.ready         = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // tracing, invalid cycle, then trace plus break at the top address
    write_reg(RegBreakAddress, 16'hFFFF);
    send_cycle(16'h0000, 8'h00, 1'b0, 1'b1, 1'b0);
    send_cycle(16'hFFFE, 8'hFF, 1'b1, 1'b0, 1'b1);
    send_cycle(16'hFFFF, 8'hFF, 1'b1, 1'b0, 1'b0);
    send_cycle(16'h1234, 8'h5A, 1'b1, 1'b1, 1'b1);
    send_cycle(16'hFFFF, 8'h00, 1'b0, 1'b1, 1'b0);
    // halted: ignored, and an unlisted index does not release it
    send_cycle(16'hFFFF, 8'h00, 1'b0, 1'b1, 1'b1);
    wait_idle();
    write_reg(RegUnlisted, 16'hFFFF);
    send_cycle(16'hFFFF, 8'hA5, 1'b1, 1'b1, 1'b1);
    wait_idle();
    // quiet: break record alone
    write_reg(RegQuietMode, 16'h0001);
    send_cycle(16'hFFFF, 8'h11, 1'b1, 1'b0, 1'b1);
    wait_idle();
    write_reg(RegCheckData, 16'hFFFF);
    write_reg(RegExpectedData, 16'hFFA5);
    write_reg(RegQuietMode, 16'hFFFE);
    send_cycle(16'hFFFF, 8'h5A, 1'b1, 1'b1, 1'b0);
    send_cycle(16'hFFFF, 8'hA5, 1'b0, 1'b1, 1'b0);
    wait_idle();
    write_reg(RegCheckData, 16'h0000);
    write_reg(RegCheckDirection, 16'h0001);
    write_reg(RegExpectedDirection, 16'h0001);
    send_cycle(16'hFFFF, 8'h00, 1'b0, 1'b1, 1'b1);
    send_cycle(16'hFFFF, 8'h00, 1'b1, 1'b1, 1'b1);
    wait_idle();
    // match_any overrides failing data and direction checks
    write_reg(RegCheckData, 16'h0001);
    write_reg(RegExpectedData, 16'h0000);
    write_reg(RegMatchAny, 16'h0001);
    send_cycle(16'hFFFF, 8'h33, 1'b0, 1'b0, 1'b1);
    wait_idle();
    write_reg(RegMatchAny, 16'h0000);
    write_reg(RegCheckData, 16'h0000);
    write_reg(RegCheckDirection, 16'h0000);
    write_reg(RegBreakAddress, 16'h0000);
    send_cycle(16'h0000, 8'h80, 1'b1, 1'b1, 1'b1);

    while (counted < TargetItems) begin
      wait_idle();
      new_settings();
      phase_n = 0;
      while (!halted && phase_n < PhaseItems && counted < TargetItems) random_cycle();
      if (halted) begin
        repeat ($urandom_range(1, 3)) random_cycle();
        if ($urandom_range(3) == 0) begin
          wait_idle();
          write_reg(RegUnlisted, 16'($urandom_range(16'hFFFF)));
          random_cycle();
        end
      end
    end

    bus.valid = 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/bbt_pkg.sv
design/bbt_bus_if.sv
design/bbt_rec_if.sv
design/bbt_cfg_if.sv
design/bbt_fifo.sv
design/bbt_front.sv
design/bbt_back.sv
design/bus_breakpoint_tracer_unit.sv
design/bbt_checker.sv
tb/trace_record_checker.sv
tb/tb.sv
